// File: rtl/ppu_video_address_map_macros.svh
// ----------------------------------------------------------------------------
// ppu_video_address_map_macros.svh
// Assertion helpers for the video address map checkers.
// ----------------------------------------------------------------------------
`ifndef PPU_VIDEO_ADDRESS_MAP_MACROS_SVH
`define PPU_VIDEO_ADDRESS_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Types and constants shared by the video address map and its checker.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int ADDR_W     = 16;
    localparam int VADDR_W    = 14;   // bus address is masked to this
    localparam int DATA_W     = 8;
    localparam int PAT_AW     = 13;   // 8 KiB character store
    localparam int NT_AW      = 12;   // 4 KiB name-table store
    localparam int PAL_AW     = 5;    // 32-byte palette
    localparam int PAL_DEPTH  = 1 << PAL_AW;
    localparam int PAGE_AW    = 10;   // 1 KiB pages

    localparam logic [5:0] PAL_PAGE = 6'h3F;  // addr[13:8] of palette space

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE = 1'b0;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2
    } t_opcode;

    // Where the byte for a read comes from
    typedef enum logic [1:0] {
        SRC_NONE      = 2'd0,
        SRC_PATTERN   = 2'd1,
        SRC_NAMETABLE = 2'd2,
        SRC_PALETTE   = 2'd3
    } t_rd_src;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } t_in_beat;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                access_error;
    } t_out_beat;

endpackage

// File: rtl/ppu_video_address_map.sv
// ----------------------------------------------------------------------------
// ppu_video_address_map
// Video-side memory map: 8 KiB character store, 4 KiB name tables with
// selectable mirroring, 32-byte palette and the buffered read port.
//
// Input channel carries one access beat (opcode, address, write_data);
// output channel returns exactly one beat per access (read_data,
// access_error). Both use valid/stall; a beat moves when valid is high and
// stall is low.
// Path: the synchronous store read fills the in-flight stage, then the
// result moves into the output register. Only one access is in flight:
// no new beat is taken while the previous one is in the store read;
// the next beat is taken in the cycle the previous result lands in the
// output register, as long as that register is free or being drained.
// Receiver stall: the result holds in the output register, and o_in_stall
// stays high until it has been taken.
// Reset: mirror mode, palette and read buffer clear at once; then the
// name-table store is swept to zero, one byte a cycle, while o_in_stall
// is high. Configuration writes are taken during the sweep.
// Character store is not cleared: read only what has been loaded.
// ----------------------------------------------------------------------------
module ppu_video_address_map (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // access channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pva_pkg::t_in_beat              i_in_data,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pva_pkg::t_out_beat             o_out_data,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pva_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pva_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pva_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import pva_pkg::*;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] r_pat_mem [1 << PAT_AW];
    logic [DATA_W-1:0] r_nt_mem  [1 << NT_AW];
    logic [DATA_W-1:0] r_pal     [PAL_DEPTH];
    logic [DATA_W-1:0] r_pat_q;
    logic [DATA_W-1:0] r_nt_q;
    logic [DATA_W-1:0] r_rdbuf;

    // Control
    logic [1:0]        r_mirror_mode;
    logic              r_clr_busy;
    logic [NT_AW-1:0]  r_clr_addr;

    // Access in flight (store read pending)
    logic              r_s1_valid;
    t_rd_src           r_s1_src;
    logic              r_s1_err;
    logic [PAL_AW-1:0] r_s1_pal_idx;

    // Output register
    logic              r_out_valid;
    t_out_beat         r_out_data;
    t_out_beat         n_out_data;
    logic [DATA_W-1:0] n_rdbuf;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (cfg_idx == REG_MIRROR_MODE) begin
            prdata = {{(CFG_DATA_W-2){1'b0}}, r_mirror_mode};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_mode <= 2'd0;
        end else if (cfg_wr && cfg_idx == REG_MIRROR_MODE) begin
            r_mirror_mode <= pwdata[1:0];
        end
    end

    // ------------------------------------------------------------------
    // Accept and decode
    // ------------------------------------------------------------------
    logic               in_ready;
    logic               in_acc;
    logic [VADDR_W-1:0] va;
    logic               in_pat;
    logic               in_pal;
    logic               in_nt;
    logic [1:0]         page;
    logic [1:0]         phys_page;
    logic [NT_AW-1:0]   nt_idx;

    // One access in flight; the output slot must be free or draining.
    assign in_ready   = !r_clr_busy && !r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !in_ready;
    assign in_acc     = i_in_valid && in_ready;

    assign va     = i_in_data.address[VADDR_W-1:0];
    assign in_pat = !va[VADDR_W-1];
    assign in_pal = (va[VADDR_W-1:8] == PAL_PAGE);
    assign in_nt  = !in_pat && !in_pal;   // 0x3000 aliases 0x2000 via page bits

    // Page mirroring; mode three falls into four-screen through its high bit.
    assign page = va[PAGE_AW+1:PAGE_AW];
    always_comb begin
        if (r_mirror_mode[1]) begin
            phys_page = page;
        end else if (r_mirror_mode[0]) begin
            phys_page = {1'b0, page[0]};
        end else begin
            phys_page = {1'b0, page[1]};
        end
    end
    assign nt_idx = {phys_page, va[PAGE_AW-1:0]};

    t_rd_src dec_src;
    logic    dec_err;
    logic    dec_nt_wr;
    logic    dec_pal_wr;
    logic    dec_pat_wr;

    always_comb begin
        dec_src    = SRC_NONE;
        dec_err    = 1'b0;
        dec_nt_wr  = 1'b0;
        dec_pal_wr = 1'b0;
        dec_pat_wr = 1'b0;
        case (i_in_data.opcode)
            OP_READ: begin
                if (in_pat) begin
                    dec_src = SRC_PATTERN;
                end else if (in_pal) begin
                    dec_src = SRC_PALETTE;
                end else begin
                    dec_src = SRC_NAMETABLE;
                end
            end
            OP_WRITE: begin
                dec_err    = in_pat;
                dec_nt_wr  = in_nt;
                dec_pal_wr = in_pal;
            end
            OP_LOAD: begin
                dec_pat_wr = in_pat;
                dec_err    = !in_pat;
            end
            default: begin
                // unused opcode: no effect
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Character store
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc && dec_pat_wr) begin
            r_pat_mem[va[PAT_AW-1:0]] <= i_in_data.write_data;
        end
        if (in_acc && dec_src == SRC_PATTERN) begin
            r_pat_q <= r_pat_mem[va[PAT_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Name-table store, swept to zero after reset
    // ------------------------------------------------------------------
    logic              nt_we;
    logic [NT_AW-1:0]  nt_waddr;
    logic [DATA_W-1:0] nt_wdata;

    assign nt_we    = r_clr_busy || (in_acc && dec_nt_wr);
    assign nt_waddr = r_clr_busy ? r_clr_addr : nt_idx;
    assign nt_wdata = r_clr_busy ? '0 : i_in_data.write_data;

    always_ff @(posedge i_clk) begin
        if (nt_we) begin
            r_nt_mem[nt_waddr] <= nt_wdata;
        end
        if (in_acc && dec_src == SRC_NAMETABLE) begin
            r_nt_q <= r_nt_mem[nt_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {NT_AW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Palette: entries with low address bits 00 write both halves
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAL_DEPTH; i++) begin
                r_pal[i] <= '0;
            end
        end else if (in_acc && dec_pal_wr) begin
            if (va[1:0] != 2'b00) begin
                r_pal[va[PAL_AW-1:0]] <= i_in_data.write_data;
            end else begin
                r_pal[{1'b0, va[PAL_AW-2:0]}] <= i_in_data.write_data;
                r_pal[{1'b1, va[PAL_AW-2:0]}] <= i_in_data.write_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // In-flight stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_src     <= dec_src;
            r_s1_err     <= dec_err;
            r_s1_pal_idx <= va[PAL_AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result and read buffer
    // ------------------------------------------------------------------
    always_comb begin
        n_out_data.access_error = r_s1_err;
        n_out_data.read_data    = '0;
        n_rdbuf                 = r_rdbuf;
        case (r_s1_src)
            SRC_PATTERN: begin
                n_out_data.read_data = r_rdbuf;
                n_rdbuf              = r_pat_q;
            end
            SRC_NAMETABLE: begin
                n_out_data.read_data = r_rdbuf;
                n_rdbuf              = r_nt_q;
            end
            SRC_PALETTE: begin
                n_out_data.read_data = r_pal[r_s1_pal_idx];
                n_rdbuf              = r_pal[r_s1_pal_idx];
            end
            default: begin
                // no read: buffer unchanged
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdbuf <= '0;
        end else if (r_s1_valid) begin
            r_rdbuf <= n_rdbuf;
        end
    end

    // The accept rule guarantees the output slot is free when stage 1 moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/pva_checker.sv
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks on the video address map, bound to the top level.
// ----------------------------------------------------------------------------
`include "ppu_video_address_map_macros.svh"

module pva_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  pva_pkg::t_out_beat             o_out_data
);
    import pva_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a held result keeps its beat
    `PVA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // no new access while a result waits on a stalled receiver
    `PVA_ASSERT_NOW(a_no_accept_full, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall, "access taken with output blocked")

    // every accepted access is followed by a valid result
    `PVA_ASSERT_NOW(a_latency, i_clk, i_rst_n, in_acc, ##2 o_out_valid, "result missing after access")

    // refused writes and loads never return read data
    `PVA_ASSERT_NOW(a_err_no_data, i_clk, i_rst_n, o_out_valid && o_out_data.access_error, o_out_data.read_data == '0, "error beat carries read data")

endmodule

bind ppu_video_address_map pva_checker u_pva_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: dv/ppu_video_address_map_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppu_video_address_map_test
// Self-checking bench for the video address map. An access stream of
// directed and random beats runs under several mirror modes with random
// gaps on the access side and random stall on the result side. A shadow
// copy of the name tables, palette, character store and read buffer
// predicts every result beat, which is then checked field by field.
// ----------------------------------------------------------------------------

// 14-bit video space boundaries
localparam logic [13:0] NT_BASE  = 14'h2000;
localparam logic [13:0] PAL_BASE = 14'h3F00;

// Shadow of the map's storage; predicts one result beat per access beat.
class vram_scoreboard;
    logic [7:0]         pattern_mem [8192];
    logic [7:0]         nametable_mem [4096];
    logic [7:0]         palette_mem [32];
    logic [7:0]         read_latch;
    logic [1:0]         mirror_mode;
    pva_pkg::t_out_beat awaited_replies [$];
    int                 mismatches;

    function new();
        foreach (nametable_mem[i]) nametable_mem[i] = 8'h00;
        foreach (palette_mem[i]) palette_mem[i] = 8'h00;
        read_latch  = 8'h00;
        mirror_mode = 2'd0;
        mismatches  = 0;
    endfunction

    function void set_mirror(logic [1:0] mode);
        mirror_mode = mode;
    endfunction

    // Physical name-table byte behind a name-table space address.
    // High mode bit wins, so the spare mode acts as four-screen.
    function logic [11:0] nametable_slot(logic [13:0] a);
        logic [1:0] page;
        logic [1:0] phys;
        page = a[11:10];
        if (mirror_mode[1])
            phys = page;
        else if (mirror_mode[0])
            phys = {1'b0, page[0]};
        else
            phys = {1'b0, page[1]};
        return {phys, a[9:0]};
    endfunction

    function pva_pkg::t_out_beat map_access(pva_pkg::t_in_beat b);
        pva_pkg::t_out_beat r;
        logic [13:0]        a;
        logic [7:0]         fetched;
        r = '0;
        a = b.address[13:0];
        case (b.opcode)
            pva_pkg::OP_READ: begin
                if (a >= PAL_BASE) begin
                    // palette reads bypass the buffer but still refill it
                    r.read_data = palette_mem[a[4:0]];
                    read_latch  = r.read_data;
                end else begin
                    if (a < NT_BASE)
                        fetched = pattern_mem[a[12:0]];
                    else
                        fetched = nametable_mem[nametable_slot(a)];
                    r.read_data = read_latch;
                    read_latch  = fetched;
                end
            end
            pva_pkg::OP_WRITE: begin
                if (a < NT_BASE) begin
                    r.access_error = 1'b1;
                end else if (a < PAL_BASE) begin
                    nametable_mem[nametable_slot(a)] = b.write_data;
                end else if (a[1:0] != 2'b00) begin
                    palette_mem[a[4:0]] = b.write_data;
                end else begin
                    // backdrop entries are shared with their 0x10 mirror
                    palette_mem[{1'b0, a[3:0]}] = b.write_data;
                    palette_mem[{1'b1, a[3:0]}] = b.write_data;
                end
            end
            pva_pkg::OP_LOAD: begin
                if (a < NT_BASE)
                    pattern_mem[a[12:0]] = b.write_data;
                else
                    r.access_error = 1'b1;
            end
            default: ;  // spare opcode: no state change, zero result
        endcase
        return r;
    endfunction

    function void note_access(pva_pkg::t_in_beat b);
        awaited_replies.push_back(map_access(b));
    endfunction

    function void check_reply(pva_pkg::t_out_beat got);
        pva_pkg::t_out_beat want;
        if (awaited_replies.size() == 0) begin
            $error("unexpected result beat: read_data=%02h access_error=%0b",
                   got.read_data, got.access_error);
            mismatches++;
            return;
        end
        want = awaited_replies.pop_front();
        if (got.read_data !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, got.read_data);
            mismatches++;
        end
        if (got.access_error !== want.access_error) begin
            $error("access_error: expected %0b, got %0b",
                   want.access_error, got.access_error);
            mismatches++;
        end
    endfunction
endclass

module ppu_video_address_map_test;
    import pva_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int MAX_WAIT      = 12;
    // Covers the name-table sweep after reset with lots of margin.
    localparam int IDLE_LIMIT    = 20000;
    // Extra quiet time after the last result has drained.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 222;
    localparam int MOOD_SPAN     = 40;

    localparam logic [1:0] OP_SPARE       = 2'd3;
    localparam logic [1:0] MIRROR_PAIR_01 = 2'd0;  // pages 0/1 and 2/3 shared
    localparam logic [1:0] MIRROR_PAIR_02 = 2'd1;  // pages 0/2 and 1/3 shared
    localparam logic [1:0] MIRROR_FOUR    = 2'd2;  // four separate pages
    localparam logic [1:0] MIRROR_SPARE   = 2'd3;  // decodes as four-screen

    // Fixed order for the first phases so the extremes all get run.
    localparam logic [1:0] PHASE_MODES [4] =
        '{MIRROR_PAIR_02, MIRROR_FOUR, MIRROR_SPARE, MIRROR_PAIR_01};

    // ------------------------------------------------------------------
    // Clock, reset and the block's pins
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_beat;

    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] cfg_rdata;
    logic                  pready;

    ppu_video_address_map dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (cfg_rdata),
        .pready      (pready)
    );

    vram_scoreboard scoreboard;

    // Per-stretch switches that turn idling off on either side.
    bit feed_quiet = 1'b0;
    bit sink_quiet = 1'b0;

    // Character-store bytes already loaded; only these are ever read back.
    int loaded_rows [$];

    // ------------------------------------------------------------------
    // Monitor: all scoreboard sampling happens here, on values from before the edge.
    // Input beats are noted before result beats are checked.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                scoreboard.note_access(in_beat);
            if (out_valid && !out_stall)
                scoreboard.check_reply(out_beat);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: too long with no beat moving on any port.
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall before each beat, none in quiet stretches.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever begin
            hold = sink_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // ------------------------------------------------------------------
    // Access side helpers
    // ------------------------------------------------------------------

    // Drive one access beat after a random gap; returns at the edge that
    // takes it, with valid still high so a back-to-back beat can follow.
    task automatic send_access(t_in_beat b);
        int gap;
        gap = feed_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop feeding and wait for every outstanding result to drain.
    task automatic settle_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup + access cycle on the config port; only called with no access in flight.
    task automatic write_mirror(logic [1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MIRROR_MODE, 2'b00};
        pwdata  <= CFG_DATA_W'(mode);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scoreboard.set_mirror(mode);
    endtask

    function automatic t_in_beat beat_of(t_opcode op, logic [15:0] addr, logic [7:0] d);
        t_in_beat b;
        b.opcode     = op;
        b.address    = addr;
        b.write_data = d;
        return b;
    endfunction

    // Bits above the 14-bit video space are don't-care; randomize them.
    function automatic logic [15:0] on_bus(logic [13:0] a);
        return {2'($urandom), a};
    endfunction

    // Offsets cluster at page edges so reads often hit earlier writes.
    function automatic logic [9:0] pick_offset();
        case ($urandom_range(0, 3))
            0:       return 10'($urandom_range(0, 7));
            1:       return 10'($urandom_range(10'h3F8, 10'h3FF));
            default: return 10'($urandom);
        endcase
    endfunction

    // Any page, either the 0x2000 or 0x3000 alias, kept out of palette space.
    function automatic logic [13:0] nametable_addr(logic [9:0] off);
        logic [13:0] a;
        a = {1'b1, 1'($urandom), 2'($urandom), off};
        if (a >= PAL_BASE)
            a[12] = 1'b0;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          sent;
        int          next_mood;
        int          roll;
        int          row;
        logic [9:0]  off;
        logic [13:0] a;

        scoreboard = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Mode write lands while the name tables are still being swept.
        write_mirror(MIRROR_PAIR_01);

        // Directed: buffered vs direct reads, refused writes and loads,
        // shared pages, the 0x3000 alias, palette backdrop mirroring, the
        // top of the bus range and the spare opcode.
        send_access(beat_of(OP_READ,  16'h3F00, 8'h00));
        send_access(beat_of(OP_READ,  16'h2000, 8'hFF));
        send_access(beat_of(OP_WRITE, 16'h0000, 8'hFF));    // pattern write refused
        send_access(beat_of(OP_WRITE, 16'hDFFF, 8'h00));    // masks to 0x1FFF, refused
        send_access(beat_of(OP_LOAD,  16'h2000, 8'h12));    // load above pattern space
        send_access(beat_of(OP_LOAD,  16'hFFFF, 8'hFF));
        send_access(beat_of(OP_LOAD,  16'h0000, 8'hFF));
        send_access(beat_of(OP_LOAD,  16'hDFFF, 8'hA5));
        loaded_rows.push_back(13'h0000);
        loaded_rows.push_back(13'h1FFF);
        send_access(beat_of(OP_READ,  16'h0000, 8'h00));
        send_access(beat_of(OP_READ,  16'h1FFF, 8'h00));
        send_access(beat_of(OP_WRITE, 16'h2000, 8'hFF));
        send_access(beat_of(OP_WRITE, 16'h2BFF, 8'h5A));
        send_access(beat_of(OP_READ,  16'h2400, 8'h00));    // shares page with 0x2000
        send_access(beat_of(OP_READ,  16'h3EFF, 8'h00));    // last name-table byte
        send_access(beat_of(OP_READ,  16'h3BFF, 8'h00));    // alias of 0x2BFF
        send_access(beat_of(OP_WRITE, 16'h3F10, 8'h11));    // also lands at 0x3F00
        send_access(beat_of(OP_READ,  16'h3F00, 8'h00));
        send_access(beat_of(OP_WRITE, 16'hFF04, 8'h80));    // also lands at 0x3F14
        send_access(beat_of(OP_READ,  16'h7F14, 8'h00));
        send_access(beat_of(OP_WRITE, 16'h3F01, 8'h01));    // not mirrored
        send_access(beat_of(OP_READ,  16'h3F11, 8'h00));
        send_access(beat_of(OP_WRITE, 16'hFFFF, 8'h3C));
        send_access(beat_of(OP_READ,  16'hFFFF, 8'h00));
        send_access(beat_of(t_opcode'(OP_SPARE), 16'h2000, 8'hFF));
        send_access(beat_of(OP_READ,  16'h3000, 8'h00));    // alias of 0x2000

        // Random phases, each under its own mirror mode. Every phase opens
        // with a full drain, so the mode only changes with the map idle.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_all();
            write_mirror(phase < 4 ? PHASE_MODES[phase] : 2'($urandom_range(0, 3)));
            sent      = 0;
            next_mood = 0;
            while (sent < PHASE_ITEMS) begin
                if (sent >= next_mood) begin
                    feed_quiet = ($urandom_range(0, 3) == 0);
                    sink_quiet = ($urandom_range(0, 3) == 0);
                    next_mood  = sent + MOOD_SPAN;
                end
                roll = $urandom_range(0, 99);
                if (roll < 24) begin
                    send_access(beat_of(OP_WRITE, on_bus(nametable_addr(pick_offset())),
                                        8'($urandom)));
                    sent++;
                end else if (roll < 44) begin
                    send_access(beat_of(OP_READ, on_bus(nametable_addr(pick_offset())),
                                        8'($urandom)));
                    sent++;
                end else if (roll < 54) begin
                    send_access(beat_of(OP_WRITE, on_bus({6'h3F, 8'($urandom)}),
                                        8'($urandom)));
                    sent++;
                end else if (roll < 62) begin
                    send_access(beat_of(OP_READ, on_bus({6'h3F, 8'($urandom)}),
                                        8'($urandom)));
                    sent++;
                end else if (roll < 80) begin
                    // Character store: read back only bytes already loaded.
                    if (roll < 72 || loaded_rows.size() == 0) begin
                        row = $urandom_range(0, 13'h1FFF);
                        loaded_rows.push_back(row);
                        send_access(beat_of(OP_LOAD, on_bus({1'b0, 13'(row)}),
                                            8'($urandom)));
                    end else begin
                        row = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
                        send_access(beat_of(OP_READ, on_bus({1'b0, 13'(row)}),
                                            8'($urandom)));
                    end
                    sent++;
                end else if (roll < 92) begin
                    // Write one byte, then read it twice through random aliases:
                    // the first read shows the old buffer, the second the byte
                    // (or its neighbor page, depending on mirroring).
                    off = pick_offset();
                    send_access(beat_of(OP_WRITE, on_bus(nametable_addr(off)), 8'($urandom)));
                    send_access(beat_of(OP_READ, on_bus(nametable_addr(off)), 8'($urandom)));
                    send_access(beat_of(OP_READ, on_bus(nametable_addr(off)), 8'($urandom)));
                    sent += 3;
                end else begin
                    // Noise: refused writes and loads, spare opcode anywhere.
                    case ($urandom_range(0, 2))
                        0: begin
                            a = {1'b0, 13'($urandom)};
                            send_access(beat_of(OP_WRITE, on_bus(a), 8'($urandom)));
                        end
                        1: begin
                            a = 14'($urandom_range(NT_BASE, 14'h3FFF));
                            send_access(beat_of(OP_LOAD, on_bus(a), 8'($urandom)));
                        end
                        default: begin
                            send_access(beat_of(t_opcode'(OP_SPARE), 16'($urandom),
                                                8'($urandom)));
                        end
                    endcase
                    sent++;
                end
            end
        end

        feed_quiet = 1'b0;
        settle_all();
        if (scoreboard.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
